// ===== hw/rtl/ialu_pkg.sv =====
// Package for the integer ALU: operation codes and the record that moves between pipeline cells.
// It has no dependencies. Every other file but ialu_checker uses it.
package ialu_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_REM  = 4'd4,
    OP_SHL  = 4'd5,
    OP_ASHR = 4'd6,
    OP_AND  = 4'd7,
    OP_OR   = 4'd8,
    OP_XOR  = 4'd9,
    OP_EQ   = 4'd10,
    OP_NE   = 4'd11,
    OP_SGT  = 4'd12,
    OP_SGE  = 4'd13,
    OP_SLT  = 4'd14,
    OP_SLE  = 4'd15
  } op_t;

  // Control flags that travel with each request through the divider cells.
  typedef struct packed {
    logic valid;   // the stage holds a request
    logic is_div;  // the request is a divide or remainder
    logic neg_q;   // the quotient must be negated at the end
    logic neg_r;   // the remainder must be negated at the end
    logic zero_b;  // the divisor is zero
    logic want_q;  // return the quotient (else the remainder)
  } ctl_t;

endpackage

// ===== hw/rtl/ialu_if.sv =====
// Valid/ready channel interfaces for the integer ALU.
// It depends on ialu_pkg for the operation code type.
interface ialu_req_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  ialu_pkg::op_t                action;
  logic signed [DATA_WIDTH-1:0] left_operand;
  logic signed [DATA_WIDTH-1:0] right_operand;
  modport source (output valid, action, left_operand, right_operand, input ready);
  modport sink (input valid, action, left_operand, right_operand, output ready);
endinterface

interface ialu_rsp_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_value;
  logic                         result_valid;
  modport source (output valid, result_value, result_valid, input ready);
  modport sink (input valid, result_value, result_valid, output ready);
endinterface

// ===== hw/rtl/ialu_cell.sv =====
// One cell of the ALU pipeline: one restoring-division step, with the other results carried along.
// It depends on ialu_pkg.
module ialu_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  ialu_pkg::ctl_t        ctl_in,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] quo_in,
  input  logic [DATA_WIDTH-1:0] dvs_in,
  input  logic [DATA_WIDTH-1:0] res_in,
  output ialu_pkg::ctl_t        ctl_out,
  output logic [DATA_WIDTH-1:0] rem_out,
  output logic [DATA_WIDTH-1:0] quo_out,
  output logic [DATA_WIDTH-1:0] dvs_out,
  output logic [DATA_WIDTH-1:0] res_out
);

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] quo_next;

  // The dividend is shifted out of quo one bit a step while quotient bits shift in.
  always_comb begin
    trial = {rem_in, quo_in[DATA_WIDTH-1]};
    diff  = trial - {1'b0, dvs_in};
    if (!diff[DATA_WIDTH]) begin
      rem_next = diff[DATA_WIDTH-1:0];
      quo_next = {quo_in[DATA_WIDTH-2:0], 1'b1};
    end else begin
      rem_next = trial[DATA_WIDTH-1:0];
      quo_next = {quo_in[DATA_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      quo_out <= quo_next;
      dvs_out <= dvs_in;
      res_out <= res_in;
    end
  end

endmodule

// ===== hw/rtl/integer_alu_with_compare_core.sv =====
// Top level of the pipelined signed integer ALU with compares.
// It depends on ialu_pkg, ialu_if and ialu_cell.
//
//   channel  direction  fields
//   req      in         action, left_operand, right_operand
//   rsp      out        result_value, result_valid
//
// One request enters per cycle while rsp is not stalled. Every request goes through an entry
// stage, one division cell per quotient bit, and an output stage.
// The pipeline advances whenever the output register is empty or being taken,
// so a stall on rsp holds every stage. Reset is synchronous and empties all stages.
module integer_alu_with_compare_core #(
  parameter int DATA_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  ialu_req_if.sink   req,
  ialu_rsp_if.source rsp
);

  localparam int SHW = $clog2(DATA_WIDTH);
  localparam logic [DATA_WIDTH-1:0] DW_C = DATA_WIDTH'(DATA_WIDTH);

  logic en;
  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // Entry stage: everything except division resolves here.
  logic [DATA_WIDTH-1:0] a, b, ma, mb, res0, sh_amt;
  logic [SHW-1:0]        sh;
  logic                  slt, na, nb;
  ialu_pkg::ctl_t        ctl0;

  always_comb begin
    a = req.left_operand;
    b = req.right_operand;
    na = a[DATA_WIDTH-1];
    nb = b[DATA_WIDTH-1];
    ma = na ? -a : a;
    mb = nb ? -b : b;
    sh_amt = b % DW_C;
    sh = sh_amt[SHW-1:0];
    slt = $signed(a) < $signed(b);
    res0 = '0;
    unique case (req.action)
      ialu_pkg::OP_ADD:  res0 = a + b;
      ialu_pkg::OP_SUB:  res0 = a - b;
      ialu_pkg::OP_MUL:  res0 = a * b;
      ialu_pkg::OP_DIV,
      ialu_pkg::OP_REM:  res0 = '0;
      ialu_pkg::OP_SHL:  res0 = a << sh;
      ialu_pkg::OP_ASHR: res0 = $unsigned($signed(a) >>> sh);
      ialu_pkg::OP_AND:  res0 = a & b;
      ialu_pkg::OP_OR:   res0 = a | b;
      ialu_pkg::OP_XOR:  res0 = a ^ b;
      ialu_pkg::OP_EQ:   res0 = {{(DATA_WIDTH-1){1'b0}}, a == b};
      ialu_pkg::OP_NE:   res0 = {{(DATA_WIDTH-1){1'b0}}, a != b};
      ialu_pkg::OP_SGT:  res0 = {{(DATA_WIDTH-1){1'b0}}, !slt && (a != b)};
      ialu_pkg::OP_SGE:  res0 = {{(DATA_WIDTH-1){1'b0}}, !slt};
      ialu_pkg::OP_SLT:  res0 = {{(DATA_WIDTH-1){1'b0}}, slt};
      ialu_pkg::OP_SLE:  res0 = {{(DATA_WIDTH-1){1'b0}}, slt || (a == b)};
      default:           res0 = '0;
    endcase
    ctl0.valid  = req.valid;
    ctl0.is_div = (req.action == ialu_pkg::OP_DIV) || (req.action == ialu_pkg::OP_REM);
    ctl0.want_q = (req.action == ialu_pkg::OP_DIV);
    ctl0.neg_q  = na ^ nb;
    ctl0.neg_r  = na;
    ctl0.zero_b = (b == '0);
  end

  ialu_pkg::ctl_t        ctl [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] rem [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] quo [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] dvs [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] res [DATA_WIDTH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (en) begin
      ctl[0] <= ctl0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      quo[0] <= ma;
      dvs[0] <= mb;
      res[0] <= res0;
    end
  end

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    ialu_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl[i]),
      .rem_in  (rem[i]),
      .quo_in  (quo[i]),
      .dvs_in  (dvs[i]),
      .res_in  (res[i]),
      .ctl_out (ctl[i+1]),
      .rem_out (rem[i+1]),
      .quo_out (quo[i+1]),
      .dvs_out (dvs[i+1]),
      .res_out (res[i+1])
    );
  end

  // Output stage: apply signs and pick the divider or plain result.
  ialu_pkg::ctl_t        cl;
  logic [DATA_WIDTH-1:0] q_s, r_s, final_v;
  logic                  final_ok;

  always_comb begin
    cl = ctl[DATA_WIDTH];
    q_s = cl.neg_q ? -quo[DATA_WIDTH] : quo[DATA_WIDTH];
    r_s = cl.neg_r ? -rem[DATA_WIDTH] : rem[DATA_WIDTH];
    final_ok = 1'b1;
    final_v  = res[DATA_WIDTH];
    if (cl.is_div) begin
      if (cl.zero_b) begin
        final_ok = 1'b0;
        final_v  = '0;
      end else begin
        final_v = cl.want_q ? q_s : r_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= cl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.result_value <= final_v;
      rsp.result_valid <= final_ok;
    end
  end

endmodule

// ===== hw/rtl/ialu_checker.sv =====
// Port checker for the integer ALU, with its bind to the top level.
// It depends on ialu_if and integer_alu_with_compare_core.
module ialu_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic                  rsp_result_valid,
  input logic [DATA_WIDTH-1:0] rsp_result_value
);

  // The block takes a request exactly when its output slot can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    req_ready == (!rsp_valid || rsp_ready))
    else $error("ready does not follow the output slot");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value))
    else $error("stalled result changed");

  a_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result after reset");

  // An invalid result always carries a zero value.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_result_valid |-> rsp_result_value == '0)
    else $error("invalid result is not zero");

endmodule

bind integer_alu_with_compare_core ialu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_ialu_checker (
  .clk              (clk),
  .rst              (rst),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_result_valid (rsp.result_valid),
  .rsp_result_value (rsp.result_value)
);

// ===== tb/tb_integer_alu_with_compare_core.sv =====
// Testbench for the pipelined signed integer ALU: directed corner requests, then random
// bursts, checked in order against a behavioral predictor held in a small scoreboard class.
// It depends on ialu_pkg, ialu_if and the core under test.
module tb_integer_alu_with_compare_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam int LATENCY = W + 2;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic [W-1:0] word_t;
  typedef struct packed {
    word_t value;
    logic  ok;
  } alu_result_t;

  class alu_scoreboard;
    alu_result_t pending[$];
    int          failures;

    function alu_result_t compute(ialu_pkg::op_t op, word_t a, word_t b);
      alu_result_t r;
      word_t ma, mb, q;
      int    sh;
      ma = a[W-1] ? -a : a;
      mb = b[W-1] ? -b : b;
      sh = b % W;
      r.ok = 1'b1;
      r.value = '0;
      case (op)
        ialu_pkg::OP_ADD:  r.value = a + b;
        ialu_pkg::OP_SUB:  r.value = a - b;
        ialu_pkg::OP_MUL:  r.value = a * b;
        ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
          if (b == 0) begin
            r.ok = 1'b0;
          end else if (op == ialu_pkg::OP_DIV) begin
            q = ma / mb;
            r.value = (a[W-1] != b[W-1]) ? -q : q;
          end else begin
            q = ma % mb;
            r.value = a[W-1] ? -q : q;
          end
        end
        ialu_pkg::OP_SHL:  r.value = a << sh;
        ialu_pkg::OP_ASHR: r.value = $signed(a) >>> sh;
        ialu_pkg::OP_AND:  r.value = a & b;
        ialu_pkg::OP_OR:   r.value = a | b;
        ialu_pkg::OP_XOR:  r.value = a ^ b;
        ialu_pkg::OP_EQ:   r.value = word_t'(a == b);
        ialu_pkg::OP_NE:   r.value = word_t'(a != b);
        ialu_pkg::OP_SGT:  r.value = word_t'($signed(a) > $signed(b));
        ialu_pkg::OP_SGE:  r.value = word_t'($signed(a) >= $signed(b));
        ialu_pkg::OP_SLT:  r.value = word_t'($signed(a) < $signed(b));
        default:           r.value = word_t'($signed(a) <= $signed(b));
      endcase
      return r;
    endfunction

    function void note_request(ialu_pkg::op_t op, word_t a, word_t b);
      pending.push_back(compute(op, a, b));
    endfunction

    function void check_result(word_t value, logic ok);
      alu_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%h valid=%b", $realtime, value, ok);
        failures++;
        return;
      end
      exp_r = pending.pop_front();
      if (value !== exp_r.value) begin
        $display("%0t: result_value expected %h actual %h", $realtime, exp_r.value, value);
        failures++;
      end
      if (ok !== exp_r.ok) begin
        $display("%0t: result_valid expected %b actual %b", $realtime, exp_r.ok, ok);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  ialu_req_if #(.DATA_WIDTH(W)) req ();
  ialu_rsp_if #(.DATA_WIDTH(W)) rsp ();

  integer_alu_with_compare_core #(.DATA_WIDTH(W)) dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  alu_scoreboard board = new();
  longint cycles = 0;
  bit     sending_done = 1'b0;
  bit     long_hold = 1'b0;

  initial begin
    req.valid = 1'b0;
    req.action = ialu_pkg::OP_ADD;
    req.left_operand = '0;
    req.right_operand = '0;
    rsp.ready = 1'b0;
  end

  // Inputs and outputs are sampled at the rising edge; the scoreboard sees both sides there.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && req.valid && req.ready)
      board.note_request(req.action, req.left_operand, req.right_operand);
    if (!rst && rsp.valid && rsp.ready)
      board.check_result(rsp.result_value, rsp.result_valid);
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off to fill the pipeline.
  initial begin
    int mode;
    repeat (2) @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        rsp.ready <= 1'b0;
        repeat (150) @(negedge clk);
        long_hold = 1'b0;
      end
      mode = (cycles / 200) % 3;
      if (mode == 0)      rsp.ready <= 1'b1;
      else if (mode == 1) rsp.ready <= ($urandom_range(0, 3) != 0);
      else                rsp.ready <= ($urandom_range(0, 1) != 0);
    end
  end

  function automatic word_t pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4: return word_t'($urandom_range(0, 40));
      5: return -word_t'($urandom_range(1, 40));
      default: return $urandom;
    endcase
  endfunction

  // Offers one request, holding it until accepted; valid stays high across back-to-back items.
  task automatic send_request(ialu_pkg::op_t op, word_t a, word_t b);
    req.valid <= 1'b1;
    req.action <= op;
    req.left_operand <= a;
    req.right_operand <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender(int n);
    req.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  initial begin
    int burst, wait_cycles;
    ialu_pkg::op_t op;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    for (int k = 0; k < 16; k++)
      send_request(ialu_pkg::op_t'(k), 32'h8000_0000, 32'hffff_ffff);
    send_request(ialu_pkg::OP_DIV, 32'h1234_5678, '0);
    send_request(ialu_pkg::OP_REM, 32'h8000_0000, '0);
    send_request(ialu_pkg::OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff);
    send_request(ialu_pkg::OP_SHL, 32'h0000_0001, 32'hffff_ffe3);
    send_request(ialu_pkg::OP_ASHR, 32'h8000_0000, 32'h0000_001f);
    send_request(ialu_pkg::OP_DIV, 32'hffff_fff9, 32'h0000_0002);
    send_request(ialu_pkg::OP_REM, 32'h0000_0007, 32'hffff_fffe);
    send_request(ialu_pkg::OP_SLT, 32'h7fff_ffff, 32'h8000_0000);
    pause_sender(3);
    long_hold = 1'b1;
    for (int n = 0; n < 1550; ) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst; j++) begin
        op = ialu_pkg::op_t'($urandom_range(0, 15));
        send_request(op, pick_operand(), pick_operand());
        n++;
      end
      wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (wait_cycles > 0) pause_sender(wait_cycles);
    end
    req.valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
